FILE: rtl/eswtb_pkg.sv
// Shared types and constants for the elapsed and stopwatch timer bank.
// No dependencies; imported by the controller, the datapath and the top level.
package eswtb_pkg;

    // Default bank sizes
    localparam int DEF_NUM_ELAPSED = 8;
    localparam int DEF_NUM_WATCHES = 8;

    // Field widths
    localparam int OP_W    = 3;
    localparam int IDX_W   = 3;
    localparam int TICK_W  = 8;
    localparam int COUNT_W = 16;
    localparam int STATE_W = 2;

    // Packed stream widths, padded to whole bytes
    localparam int IN_W  = OP_W + IDX_W + TICK_W;
    localparam int OUT_W = COUNT_W + STATE_W;
    localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 3'd0,
        OP_READ_EL    = 3'd1,
        OP_RESET_EL   = 3'd2,
        OP_READ_WATCH = 3'd3,
        OP_START      = 3'd4,
        OP_STOP       = 3'd5,
        OP_PAUSE      = 3'd6,
        OP_CONTINUE   = 3'd7
    } op_t;

    // Stopwatch states
    typedef enum logic [STATE_W-1:0] {
        WS_STOPPED = 2'd0,
        WS_RUNNING = 2'd1,
        WS_PAUSED  = 2'd2
    } ws_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture the input beat
        logic exec;   // apply the captured operation and register the result
    } dp_cmd_t;

endpackage

FILE: rtl/elapsed_and_stopwatch_timer_bank.sv
// Elapsed and stopwatch timer bank: usage
// Input channel s_axis_*: one beat per operation (tick, read or reset an
// elapsed timer, read/start/stop/pause/continue a stopwatch).
// Output channel m_axis_*: exactly one result beat per input beat, in order,
// carrying the addressed timer's count and stopwatch state after the
// operation (zeros for tick and for an index beyond the bank).
// Flow: an accepted input beat is captured, then applied in the execute step,
// which registers its result, valid from then on; it leaves when the receiver
// is ready, and the next input beat is accepted only after it has left, so
// items do not overlap. The three-step controller sequence (capture, execute,
// hand off) sets this order; all timers update in parallel in the execute step.
// A stalled receiver holds the result beat steady and keeps s_axis_tready
// low until the beat is taken.
// Reset (rst_n low, asynchronous): all counts clear to zero, all
// stopwatches stop, no result is pending.
// Depends on eswtb_pkg, eswtb_ctrl and eswtb_dp.
module elapsed_and_stopwatch_timer_bank
    import eswtb_pkg::*;
#(
    parameter int NUM_ELAPSED = DEF_NUM_ELAPSED,
    parameter int NUM_WATCHES = DEF_NUM_WATCHES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // op [2:0], timer_index [5:3], tick_count [13:6], zero [15:14]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // count_value [15:0], watch_state [17:16], zero [23:18]
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    dp_cmd_t            cmd;
    logic [COUNT_W-1:0] count_value;
    logic [STATE_W-1:0] watch_state;

    eswtb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    eswtb_dp #(
        .NUM_ELAPSED (NUM_ELAPSED),
        .NUM_WATCHES (NUM_WATCHES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .op          (s_axis_tdata[OP_W-1:0]),
        .timer_index (s_axis_tdata[OP_W+IDX_W-1:OP_W]),
        .tick_count  (s_axis_tdata[IN_W-1:OP_W+IDX_W]),
        .count_value (count_value),
        .watch_state (watch_state)
    );

    // Pack the result beat
    assign m_axis_tdata = M_TDATA_W'({watch_state, count_value});

endmodule

FILE: rtl/eswtb_ctrl.sv
// Controller state machine for the timer bank: sequences capture, execute
// and result hand-off. Depends on eswtb_pkg.
module eswtb_ctrl
    import eswtb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and outputs
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/eswtb_dp.sv
// Datapath of the timer bank: elapsed and stopwatch register banks, the
// captured command and the result register. Depends on eswtb_pkg.
module eswtb_dp
    import eswtb_pkg::*;
#(
    parameter int NUM_ELAPSED = DEF_NUM_ELAPSED,
    parameter int NUM_WATCHES = DEF_NUM_WATCHES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    input  logic [OP_W-1:0]    op,
    input  logic [IDX_W-1:0]   timer_index,
    input  logic [TICK_W-1:0]  tick_count,
    output logic [COUNT_W-1:0] count_value,
    output logic [STATE_W-1:0] watch_state
);

    // Captured command
    op_t                op_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [TICK_W-1:0]  tick_reg;

    // Timer banks
    logic [COUNT_W-1:0] el_reg   [NUM_ELAPSED];
    logic [COUNT_W-1:0] el_next  [NUM_ELAPSED];
    logic [COUNT_W-1:0] wc_reg   [NUM_WATCHES];
    logic [COUNT_W-1:0] wc_next  [NUM_WATCHES];
    ws_t                ws_reg   [NUM_WATCHES];
    ws_t                ws_next  [NUM_WATCHES];

    // Result
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [STATE_W-1:0] state_reg;
    logic [STATE_W-1:0] state_next;

    logic is_tick;
    logic is_el_op;

    assign is_tick  = (op_reg == OP_TICK);
    assign is_el_op = (op_reg == OP_READ_EL) || (op_reg == OP_RESET_EL);

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op_t'(op);
            idx_reg  <= timer_index;
            tick_reg <= tick_count;
        end
    end

    // Elapsed lanes: advance on tick, clear on a matching reset
    always_comb
    begin
        for (int k = 0; k < NUM_ELAPSED; k++)
        begin
            el_next[k] = el_reg[k];
            if (is_tick)
            begin
                el_next[k] = el_reg[k] + COUNT_W'(tick_reg);
            end
            else if (op_reg == OP_RESET_EL && int'(idx_reg) == k)
            begin
                el_next[k] = '0;
            end
        end
    end

    // Stopwatch lanes: advance running ones on tick, apply commands to the addressed one
    always_comb
    begin
        for (int k = 0; k < NUM_WATCHES; k++)
        begin
            wc_next[k] = wc_reg[k];
            ws_next[k] = ws_reg[k];
            if (is_tick)
            begin
                if (ws_reg[k] == WS_RUNNING)
                begin
                    wc_next[k] = wc_reg[k] + COUNT_W'(tick_reg);
                end
            end
            else if (int'(idx_reg) == k)
            begin
                case (op_reg)
                    OP_START:
                    begin
                        if (ws_reg[k] == WS_STOPPED)
                        begin
                            wc_next[k] = '0;
                            ws_next[k] = WS_RUNNING;
                        end
                    end
                    OP_STOP:
                    begin
                        ws_next[k] = WS_STOPPED;
                    end
                    OP_PAUSE:
                    begin
                        if (ws_reg[k] == WS_RUNNING)
                        begin
                            ws_next[k] = WS_PAUSED;
                        end
                    end
                    OP_CONTINUE:
                    begin
                        if (ws_reg[k] == WS_PAUSED)
                        begin
                            ws_next[k] = WS_RUNNING;
                        end
                    end
                    default:
                    begin
                        ws_next[k] = ws_reg[k];
                    end
                endcase
            end
        end
    end

    // Select the addressed timer's updated count and state; zero when out of range
    always_comb
    begin
        count_next = '0;
        state_next = '0;
        if (is_el_op)
        begin
            for (int k = 0; k < NUM_ELAPSED; k++)
            begin
                if (int'(idx_reg) == k)
                begin
                    count_next = el_next[k];
                end
            end
        end
        else if (!is_tick)
        begin
            for (int k = 0; k < NUM_WATCHES; k++)
            begin
                if (int'(idx_reg) == k)
                begin
                    count_next = wc_next[k];
                    state_next = ws_next[k];
                end
            end
        end
    end

    // Bank registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_ELAPSED; k++)
            begin
                el_reg[k] <= '0;
            end
            for (int k = 0; k < NUM_WATCHES; k++)
            begin
                wc_reg[k] <= '0;
                ws_reg[k] <= WS_STOPPED;
            end
        end
        else if (cmd.exec)
        begin
            for (int k = 0; k < NUM_ELAPSED; k++)
            begin
                el_reg[k] <= el_next[k];
            end
            for (int k = 0; k < NUM_WATCHES; k++)
            begin
                wc_reg[k] <= wc_next[k];
                ws_reg[k] <= ws_next[k];
            end
        end
    end

    // Result register, held until the beat is taken
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            count_reg <= count_next;
            state_reg <= state_next;
        end
    end

    assign count_value = count_reg;
    assign watch_state = state_reg;

endmodule

FILE: sim/tb.sv
// Testbench for the elapsed and stopwatch timer bank: directed and random beats
// are compared field by field against a predictor of the timer banks.
// Depends on eswtb_pkg and elapsed_and_stopwatch_timer_bank.
`timescale 1ns / 100ps

module tb;
    import eswtb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // Result beat layout, highest field first
    typedef struct packed {
        logic [STATE_W-1:0] watch_state;
        logic [COUNT_W-1:0] count_value;
    } timer_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // Predicted timer state
    logic [COUNT_W-1:0] elapsed_model [DEF_NUM_ELAPSED];
    logic [COUNT_W-1:0] watch_count_model [DEF_NUM_WATCHES];
    ws_t                watch_state_model [DEF_NUM_WATCHES];

    timer_result_t expected_results [$];
    int            fail_count = 0;
    bit            idle_on = 1'b1;
    int            quiet_cycles = 0;

    elapsed_and_stopwatch_timer_bank dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Clear the predicted banks to their reset values
    function automatic void clear_timer_model();
        for (int k = 0; k < DEF_NUM_ELAPSED; k++)
            elapsed_model[k] = '0;
        for (int k = 0; k < DEF_NUM_WATCHES; k++)
        begin
            watch_count_model[k] = '0;
            watch_state_model[k] = WS_STOPPED;
        end
    endfunction

    // Apply one operation to the predicted banks and return its result beat
    function automatic timer_result_t apply_timer_op(op_t op, logic [IDX_W-1:0] idx,
                                                     logic [TICK_W-1:0] ticks);
        timer_result_t res;
        ws_t           st;
        res = '0;
        if (op == OP_TICK)
        begin
            for (int k = 0; k < DEF_NUM_ELAPSED; k++)
                elapsed_model[k] = elapsed_model[k] + COUNT_W'(ticks);
            for (int k = 0; k < DEF_NUM_WATCHES; k++)
                if (watch_state_model[k] == WS_RUNNING)
                    watch_count_model[k] = watch_count_model[k] + COUNT_W'(ticks);
        end
        else if (op == OP_READ_EL || op == OP_RESET_EL)
        begin
            if (int'(idx) < DEF_NUM_ELAPSED)
            begin
                if (op == OP_RESET_EL)
                    elapsed_model[idx] = '0;
                res.count_value = elapsed_model[idx];
            end
        end
        else if (int'(idx) < DEF_NUM_WATCHES)
        begin
            st = watch_state_model[idx];
            case (op)
                OP_START:
                    if (st == WS_STOPPED)
                    begin
                        watch_count_model[idx] = '0;
                        st = WS_RUNNING;
                    end
                OP_STOP:     st = WS_STOPPED;
                OP_PAUSE:    if (st == WS_RUNNING) st = WS_PAUSED;
                OP_CONTINUE: if (st == WS_PAUSED) st = WS_RUNNING;
                default:     ;
            endcase
            watch_state_model[idx] = st;
            res.count_value = watch_count_model[idx];
            res.watch_state = st;
        end
        return res;
    endfunction

    // Send one operation beat, with random idle cycles ahead of it
    task automatic send_timer_op(op_t op, logic [IDX_W-1:0] idx, logic [TICK_W-1:0] ticks);
        while (idle_on && $urandom_range(0, 99) < 24)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - IN_W){1'b0}}, ticks, idx, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_results.push_back(apply_timer_op(op, idx, ticks));
    endtask

    // Pick a random operation: ticks are frequent and often at the extremes
    task automatic send_random_op();
        op_t               op;
        logic [TICK_W-1:0] ticks;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            op = OP_TICK;
        else if (pick < 34)
            op = OP_RESET_EL;
        else
            op = op_t'($urandom_range(int'(OP_READ_EL), int'(OP_CONTINUE)));
        pick = $urandom_range(0, 99);
        if (pick < 20)
            ticks = '1;
        else if (pick < 30)
            ticks = '0;
        else
            ticks = TICK_W'($urandom);
        send_timer_op(op, IDX_W'($urandom_range(0, 7)), ticks);
    endtask

    // Timers read zero and stopped after reset: elapsed timers 0 and 7, stopwatch 7
    task automatic test_reset_values();
        send_timer_op(OP_READ_EL, 3'd0, 8'd0);
        send_timer_op(OP_READ_EL, 3'd7, 8'hff);
        send_timer_op(OP_READ_WATCH, 3'd7, 8'd0);
    endtask

    // Walk stopwatches 0 and 7 through every transition, legal or not, then reset and read elapsed timer 3
    task automatic test_watch_transitions();
        send_timer_op(OP_TICK, 3'd5, 8'hff);
        send_timer_op(OP_TICK, 3'd2, 8'd0);
        send_timer_op(OP_START, 3'd0, 8'd0);
        send_timer_op(OP_START, 3'd0, 8'd0);
        send_timer_op(OP_TICK, 3'd0, 8'd128);
        send_timer_op(OP_PAUSE, 3'd0, 8'd0);
        send_timer_op(OP_PAUSE, 3'd0, 8'd0);
        send_timer_op(OP_TICK, 3'd0, 8'd1);
        send_timer_op(OP_CONTINUE, 3'd0, 8'd0);
        send_timer_op(OP_CONTINUE, 3'd0, 8'd0);
        send_timer_op(OP_STOP, 3'd0, 8'd0);
        send_timer_op(OP_STOP, 3'd0, 8'd0);
        send_timer_op(OP_PAUSE, 3'd0, 8'd0);
        send_timer_op(OP_CONTINUE, 3'd0, 8'd0);
        send_timer_op(OP_START, 3'd7, 8'd0);
        send_timer_op(OP_PAUSE, 3'd7, 8'd0);
        send_timer_op(OP_START, 3'd7, 8'd0);
        send_timer_op(OP_STOP, 3'd7, 8'd0);
        send_timer_op(OP_RESET_EL, 3'd3, 8'd0);
        send_timer_op(OP_READ_EL, 3'd3, 8'd0);
    endtask

    // Random operations with idling on both sides
    task automatic test_random_mix(int n);
        repeat (n) send_random_op();
    endtask

    // Random operations with both sides always ready
    task automatic test_back_to_back(int n);
        idle_on = 1'b0;
        repeat (n) send_random_op();
        idle_on = 1'b1;
    endtask

    // Receiver: stall at random, compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        timer_result_t exp_res;
        timer_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[OUT_W-1:0];
            if (expected_results.size() == 0)
            begin
                $error("result beat with no prediction pending: %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (got.count_value !== exp_res.count_value)
                begin
                    $error("count_value: expected %0d, actual %0d",
                           exp_res.count_value, got.count_value);
                    fail_count++;
                end
                if (got.watch_state !== exp_res.watch_state)
                begin
                    $error("watch_state: expected %0d, actual %0d",
                           exp_res.watch_state, got.watch_state);
                    fail_count++;
                end
            end
        end
        m_axis_tready <= rst_n && (!idle_on || $urandom_range(0, 99) >= 24);
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        clear_timer_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_watch_transitions();
        test_random_mix(1300);
        test_back_to_back(300);
        test_random_mix(50);

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
rtl/eswtb_pkg.sv
rtl/eswtb_ctrl.sv
rtl/eswtb_dp.sv
rtl/elapsed_and_stopwatch_timer_bank.sv
sim/tb.sv
